### rtl/pfe_pkg.sv
// Shared constants, command/status types and square geometry helpers for the Playfair encryptor.
package pfe_pkg;

    localparam int SQUARE_SIDE = 5;
    localparam int CELLS       = SQUARE_SIDE * SQUARE_SIDE;
    localparam int ALPHABET    = 26;
    localparam int LETTER_W    = 5;
    localparam int CMD_W       = 2;
    localparam int CELL_W      = $clog2(CELLS);
    localparam int ROW_W       = $clog2(SQUARE_SIDE);

    // Input command codes
    localparam logic [CMD_W-1:0] CMD_KEY    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FINISH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PLAIN  = 2'd2;

    // Letter codes with a special role
    localparam logic [LETTER_W-1:0] LETTER_I    = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J    = 5'd9;
    localparam logic [LETTER_W-1:0] LETTER_X    = 5'd23;
    localparam logic [LETTER_W-1:0] LETTER_LAST = LETTER_W'(ALPHABET - 1);

    // Controller to datapath
    typedef struct packed {
        logic take_item;
        logic fill_step;
        logic read_pos;
        logic read_square;
        logic show_second;
    } pfe_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_finish;
        logic makes_pair;
        logic fill_last;
    } pfe_status_t;

    // Row of a cell index, by a short compare chain
    function automatic logic [ROW_W-1:0] cell_row(input logic [CELL_W-1:0] pos);
        logic [ROW_W-1:0] r;
        r = '0;
        for (int i = 1; i < SQUARE_SIDE; i++) begin
            if (pos >= CELL_W'(i * SQUARE_SIDE)) begin
                r = ROW_W'(i);
            end
        end
        return r;
    endfunction

    // Column of a cell index, given its row
    function automatic logic [ROW_W-1:0] cell_col(input logic [CELL_W-1:0] pos,
                                                  input logic [ROW_W-1:0]  row);
        logic [CELL_W-1:0] base;
        base = CELL_W'(row) * CELL_W'(SQUARE_SIDE);
        return ROW_W'(pos - base);
    endfunction

    // Step one row or column on, wrapping at the edge
    function automatic logic [ROW_W-1:0] wrap_next(input logic [ROW_W-1:0] v);
        return (v == ROW_W'(SQUARE_SIDE - 1)) ? '0 : ROW_W'(v + 1'b1);
    endfunction

    // Cell index from row and column
    function automatic logic [CELL_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [ROW_W-1:0] col);
        return CELL_W'(CELL_W'(row) * CELL_W'(SQUARE_SIDE) + CELL_W'(col));
    endfunction

endpackage

### rtl/pfe_ctrl.sv
// Controller state machine sequencing key entry, square fill and digraph encryption.
module pfe_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  pfe_pkg::pfe_status_t status,
    output pfe_pkg::pfe_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOOKUP = 3'd1;
    localparam logic [2:0] ST_SQUARE = 3'd2;
    localparam logic [2:0] ST_OUT1   = 3'd3;
    localparam logic [2:0] ST_OUT2   = 3'd4;
    localparam logic [2:0] ST_FILL   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (status.is_finish) begin
                        state_next = ST_FILL;
                    end else if (status.makes_pair) begin
                        state_next = ST_LOOKUP;
                    end
                end
            end
            ST_LOOKUP: state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_OUT1;
            ST_OUT1: begin
                if (out_ready) begin
                    state_next = ST_OUT2;
                end
            end
            ST_OUT2: begin
                if (out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            ST_FILL: begin
                if (status.fill_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Handshake and datapath commands
    assign in_ready        = (state_reg == ST_IDLE);
    assign out_valid       = (state_reg == ST_OUT1) || (state_reg == ST_OUT2);
    assign cmd.take_item   = in_valid && (state_reg == ST_IDLE);
    assign cmd.fill_step   = (state_reg == ST_FILL);
    assign cmd.read_pos    = (state_reg == ST_LOOKUP);
    assign cmd.read_square = (state_reg == ST_SQUARE);
    assign cmd.show_second = (state_reg == ST_OUT2);

endmodule

### rtl/pfe_datapath.sv
// Datapath: key square and position memories, pairing state and digraph lookup.
module pfe_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  pfe_pkg::pfe_cmd_t                  cmd,
    output pfe_pkg::pfe_status_t               status,
    input  logic [pfe_pkg::CMD_W-1:0]          in_cmd,
    input  logic [pfe_pkg::LETTER_W-1:0]       in_letter,
    input  logic                               in_end_of_message,
    output logic [pfe_pkg::LETTER_W-1:0]       out_cipher_letter,
    output logic                               out_pair_last,
    output logic                               out_message_last
);

    // Memories
    logic [pfe_pkg::LETTER_W-1:0] key_mem [pfe_pkg::CELLS];
    logic [pfe_pkg::CELL_W-1:0]   pos_mem [pfe_pkg::ALPHABET];

    // State
    logic [pfe_pkg::ALPHABET-1:0] used_reg;
    logic [pfe_pkg::CELL_W-1:0]   fill_index_reg;
    logic [pfe_pkg::LETTER_W-1:0] fill_k_reg;
    logic [pfe_pkg::LETTER_W-1:0] held_reg;
    logic                         held_valid_reg;
    logic [pfe_pkg::LETTER_W-1:0] prev_reg;
    logic                         prev_valid_reg;

    // Digraph in flight
    logic [pfe_pkg::LETTER_W-1:0] a_reg;
    logic [pfe_pkg::LETTER_W-1:0] b_reg;
    logic                         last_reg;
    logic [pfe_pkg::CELL_W-1:0]   pos_a_reg;
    logic [pfe_pkg::CELL_W-1:0]   pos_b_reg;
    logic [pfe_pkg::LETTER_W-1:0] c1_reg;
    logic [pfe_pkg::LETTER_W-1:0] c2_reg;

    logic                         letter_ok;
    logic [pfe_pkg::LETTER_W-1:0] ltr_i;
    logic [pfe_pkg::LETTER_W-1:0] plain_ltr;
    logic                         is_key;
    logic                         is_plain;
    logic                         square_full;
    logic                         place_en;
    logic [pfe_pkg::LETTER_W-1:0] place_ltr;

    logic [pfe_pkg::ROW_W-1:0]    ra, ca, rb, cb;
    logic [pfe_pkg::CELL_W-1:0]   addr1, addr2;

    // Decode the offered item
    always_comb begin
        letter_ok = (in_letter <= pfe_pkg::LETTER_LAST);
        ltr_i     = (in_letter == pfe_pkg::LETTER_J) ? pfe_pkg::LETTER_I : in_letter;
        plain_ltr = (prev_valid_reg && (prev_reg == ltr_i)) ? pfe_pkg::LETTER_X : ltr_i;
        is_key    = (in_cmd == pfe_pkg::CMD_KEY) && letter_ok;
        is_plain  = (in_cmd == pfe_pkg::CMD_PLAIN) && letter_ok;
    end

    assign square_full       = (fill_index_reg == pfe_pkg::CELL_W'(pfe_pkg::CELLS));
    assign status.is_finish  = (in_cmd == pfe_pkg::CMD_FINISH);
    assign status.makes_pair = is_plain && (held_valid_reg || in_end_of_message);
    assign status.fill_last  = (fill_k_reg == pfe_pkg::LETTER_LAST) || square_full;

    // Placement of a letter into the next free cell
    always_comb begin
        place_en  = 1'b0;
        place_ltr = ltr_i;
        if (cmd.fill_step) begin
            place_ltr = fill_k_reg;
            place_en  = (fill_k_reg != pfe_pkg::LETTER_J) && !used_reg[fill_k_reg]
                        && !square_full;
        end else if (cmd.take_item && is_key) begin
            place_en  = !square_full && !used_reg[ltr_i];
        end
    end

    // Memory writes and registered reads
    always_ff @(posedge aclk) begin
        if (place_en) begin
            key_mem[fill_index_reg] <= place_ltr;
            pos_mem[place_ltr]      <= fill_index_reg;
        end
        if (cmd.read_pos) begin
            pos_a_reg <= pos_mem[a_reg];
            pos_b_reg <= pos_mem[b_reg];
        end
        if (cmd.read_square) begin
            c1_reg <= key_mem[addr1];
            c2_reg <= key_mem[addr2];
        end
    end

    // Square occupancy and fill sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg       <= '0;
            fill_index_reg <= '0;
        end else if (place_en) begin
            used_reg[place_ltr] <= 1'b1;
            fill_index_reg      <= pfe_pkg::CELL_W'(fill_index_reg + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_item && status.is_finish) begin
            fill_k_reg <= '0;
        end else if (cmd.fill_step) begin
            fill_k_reg <= pfe_pkg::LETTER_W'(fill_k_reg + 1'b1);
        end
    end

    // Pairing state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            prev_valid_reg <= 1'b0;
            held_reg       <= '0;
            prev_reg       <= '0;
        end else if (cmd.take_item) begin
            if (status.is_finish) begin
                held_valid_reg <= 1'b0;
                prev_valid_reg <= 1'b0;
            end else if (is_plain) begin
                prev_reg       <= plain_ltr;
                prev_valid_reg <= !in_end_of_message;
                if (held_valid_reg) begin
                    held_valid_reg <= 1'b0;
                end else if (!in_end_of_message) begin
                    held_reg       <= plain_ltr;
                    held_valid_reg <= 1'b1;
                end
            end
        end
    end

    // Capture the digraph; an odd final letter is padded with x
    always_ff @(posedge aclk) begin
        if (cmd.take_item && status.makes_pair) begin
            last_reg <= in_end_of_message;
            if (held_valid_reg) begin
                a_reg <= held_reg;
                b_reg <= plain_ltr;
            end else begin
                a_reg <= plain_ltr;
                b_reg <= pfe_pkg::LETTER_X;
            end
        end
    end

    // Playfair rules on the looked-up cells
    always_comb begin
        ra = pfe_pkg::cell_row(pos_a_reg);
        rb = pfe_pkg::cell_row(pos_b_reg);
        ca = pfe_pkg::cell_col(pos_a_reg, ra);
        cb = pfe_pkg::cell_col(pos_b_reg, rb);
        if (ra == rb) begin
            addr1 = pfe_pkg::cell_addr(ra, pfe_pkg::wrap_next(ca));
            addr2 = pfe_pkg::cell_addr(rb, pfe_pkg::wrap_next(cb));
        end else if (ca == cb) begin
            addr1 = pfe_pkg::cell_addr(pfe_pkg::wrap_next(ra), ca);
            addr2 = pfe_pkg::cell_addr(pfe_pkg::wrap_next(rb), cb);
        end else begin
            addr1 = pfe_pkg::cell_addr(ra, cb);
            addr2 = pfe_pkg::cell_addr(rb, ca);
        end
    end

    // Result beat payload
    assign out_cipher_letter = cmd.show_second ? c2_reg : c1_reg;
    assign out_pair_last     = cmd.show_second;
    assign out_message_last  = cmd.show_second && last_reg;

endmodule

### rtl/playfair_cipher_encryptor_unit.sv
// Top level of the Playfair encryptor: controller and datapath.
//
// Input channel s_*: one beat carries a command (key letter, finish square,
// plaintext letter), a letter code and an end-of-message flag. Output channel
// m_*: one beat carries one ciphertext letter with pair and message markers.
// Key letters fill the square row by row; finish clears the pairing state,
// then walks the alphabet one letter per cycle to fill the rest.
// A key letter or a plaintext letter that completes no pair leaves the
// block ready for the next input. Finish runs a fill sweep, one step per
// alphabet letter, that ends early once the square is full. A completed
// pair is accepted, then the position memory and then the square memory
// are read, then two result beats are offered; the next input is taken
// only after the second beat. Both memories have one write port and two
// registered read ports. While a result beat is stalled by m_ready,
// payload holds and no input is taken. Reset empties the square and clears
// the pairing state; the square contents need no clearing if the user fills
// them first, which the block itself does not enforce.
module playfair_cipher_encryptor_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [pfe_pkg::CMD_W-1:0]    s_cmd,
    input  logic [pfe_pkg::LETTER_W-1:0] s_letter,
    input  logic                         s_end_of_message,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [pfe_pkg::LETTER_W-1:0] m_cipher_letter,
    output logic                         m_pair_last,
    output logic                         m_message_last
);

    pfe_pkg::pfe_cmd_t    cmd;
    pfe_pkg::pfe_status_t status;

    // Sequencer
    pfe_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Storage and cipher logic
    pfe_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .in_cmd            (s_cmd),
        .in_letter         (s_letter),
        .in_end_of_message (s_end_of_message),
        .out_cipher_letter (m_cipher_letter),
        .out_pair_last     (m_pair_last),
        .out_message_last  (m_message_last)
    );

endmodule

### rtl/pfe_checker.sv
// Port-level checks for the Playfair encryptor, bound to the top level.
module pfe_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [pfe_pkg::LETTER_W-1:0] m_cipher_letter,
    input logic                         m_pair_last,
    input logic                         m_message_last
);

    // No input is taken while a result beat is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while result beat pending");

    // The first letter of a digraph is always followed by the second
    a_pair_second: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_pair_last) |=> (m_valid && m_pair_last))
        else $error("digraph second beat missing");

    // Message end is only flagged on a digraph's second letter
    a_msg_on_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_message_last) |-> m_pair_last)
        else $error("message end on first letter of digraph");

    // A stalled beat holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_cipher_letter)
                                   && $stable(m_pair_last)))
        else $error("stalled result beat changed");

endmodule

bind playfair_cipher_encryptor_unit pfe_checker u_pfe_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_cipher_letter (m_cipher_letter),
    .m_pair_last     (m_pair_last),
    .m_message_last  (m_message_last)
);

### tb/tb_playfair_cipher_encryptor_unit.sv
// Self-checking testbench for the Playfair encryptor: random handshakes, in-bench cipher predictor.
module tb_playfair_cipher_encryptor_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import pfe_pkg::*;

    // Command code that the block ignores, and the highest 5-bit letter code
    localparam logic [CMD_W-1:0]    CMD_IGNORED = 2'd3;
    localparam logic [LETTER_W-1:0] CODE_TOP    = '1;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 40;

    typedef struct {
        logic [CMD_W-1:0]    cmd;
        logic [LETTER_W-1:0] letter;
        logic                eom;
    } plain_beat_t;

    typedef struct {
        logic [LETTER_W-1:0] letter;
        logic                pair_last;
        logic                message_last;
    } cipher_beat_t;

    logic                aclk;
    logic                aresetn          = 1'b0;
    logic                s_valid          = 1'b0;
    logic                s_ready;
    logic [CMD_W-1:0]    s_cmd            = CMD_KEY;
    logic [LETTER_W-1:0] s_letter         = '0;
    logic                s_end_of_message = 1'b0;
    logic                m_valid;
    logic                m_ready          = 1'b0;
    logic [LETTER_W-1:0] m_cipher_letter;
    logic                m_pair_last;
    logic                m_message_last;

    // Stimulus backlog and cipher letters still owed by the block
    plain_beat_t  cmd_backlog[$];
    cipher_beat_t cipher_due[$];
    plain_beat_t  drv_beat;
    cipher_beat_t want;

    int   beats_queued  = 0;
    int   beats_taken   = 0;
    int   stall_cycles  = 0;
    int   fails         = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_left     = 0;
    logic hold_request  = 1'b0;
    logic in_beat_taken = 1'b0;
    logic out_taken;

    // Predictor state: the square, each letter's cell and the pairing state
    logic [LETTER_W-1:0] sq_cell[CELLS];
    int                  cell_of[ALPHABET];
    logic [ALPHABET-1:0] used      = '0;
    int                  fill_idx  = 0;
    logic [LETTER_W-1:0] held_l    = '0;
    logic                held_v    = 1'b0;
    logic [LETTER_W-1:0] prev_l    = '0;
    logic                prev_v    = 1'b0;

    playfair_cipher_encryptor_unit u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_letter         (s_letter),
        .s_end_of_message (s_end_of_message),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cipher_letter  (m_cipher_letter),
        .m_pair_last      (m_pair_last),
        .m_message_last   (m_message_last)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Put a letter in the next free cell of the square
    function automatic void place_letter(input logic [LETTER_W-1:0] ltr);
        sq_cell[fill_idx] = ltr;
        cell_of[ltr]      = fill_idx;
        used[ltr]         = 1'b1;
        fill_idx++;
    endfunction

    // Encipher one digraph and queue its two cipher letters
    function automatic void encipher_pair(input logic [LETTER_W-1:0] a,
                                          input logic [LETTER_W-1:0] b,
                                          input logic               last);
        int ra, ca, rb, cb;
        cipher_beat_t c1, c2;
        ra = cell_of[a] / SQUARE_SIDE;
        ca = cell_of[a] % SQUARE_SIDE;
        rb = cell_of[b] / SQUARE_SIDE;
        cb = cell_of[b] % SQUARE_SIDE;
        if (ra == rb) begin
            c1.letter = sq_cell[ra * SQUARE_SIDE + (ca + 1) % SQUARE_SIDE];
            c2.letter = sq_cell[rb * SQUARE_SIDE + (cb + 1) % SQUARE_SIDE];
        end else if (ca == cb) begin
            c1.letter = sq_cell[((ra + 1) % SQUARE_SIDE) * SQUARE_SIDE + ca];
            c2.letter = sq_cell[((rb + 1) % SQUARE_SIDE) * SQUARE_SIDE + cb];
        end else begin
            c1.letter = sq_cell[ra * SQUARE_SIDE + cb];
            c2.letter = sq_cell[rb * SQUARE_SIDE + ca];
        end
        c1.pair_last    = 1'b0;
        c1.message_last = 1'b0;
        c2.pair_last    = 1'b1;
        c2.message_last = last;
        cipher_due.push_back(c1);
        cipher_due.push_back(c2);
    endfunction

    // Advance the predictor by one accepted input beat
    function automatic void playfair_step(input logic [CMD_W-1:0]    cmd,
                                          input logic [LETTER_W-1:0] ltr_in,
                                          input logic                eom);
        logic [LETTER_W-1:0] ltr;
        ltr = ltr_in;
        if (cmd == CMD_FINISH) begin
            for (int k = 0; k < ALPHABET && fill_idx < CELLS; k++) begin
                if (k != LETTER_J && !used[k]) begin
                    place_letter(LETTER_W'(k));
                end
            end
            held_v = 1'b0;
            prev_v = 1'b0;
        end else if (cmd != CMD_IGNORED && ltr < ALPHABET) begin
            if (ltr == LETTER_J) begin
                ltr = LETTER_I;
            end
            if (cmd == CMD_KEY) begin
                if (fill_idx < CELLS && !used[ltr]) begin
                    place_letter(ltr);
                end
            end else begin
                // doubled letter becomes x, compared after earlier replacement
                if (prev_v && prev_l == ltr) begin
                    ltr = LETTER_X;
                end
                prev_l = ltr;
                prev_v = 1'b1;
                if (held_v) begin
                    encipher_pair(held_l, ltr, eom);
                    held_v = 1'b0;
                    if (eom) begin
                        prev_v = 1'b0;
                    end
                end else if (eom) begin
                    // odd letter at end of message: pad with x
                    encipher_pair(ltr, LETTER_X, 1'b1);
                    prev_v = 1'b0;
                end else begin
                    held_l = ltr;
                    held_v = 1'b1;
                end
            end
        end
    endfunction

    function automatic void queue_beat(input logic [CMD_W-1:0]    cmd,
                                       input logic [LETTER_W-1:0] ltr,
                                       input logic                eom);
        plain_beat_t b;
        b.cmd    = cmd;
        b.letter = ltr;
        b.eom    = eom;
        cmd_backlog.push_back(b);
        beats_queued++;
    endfunction

    // Mostly plaintext messages, with doubled letters, j, finishes and junk mixed in
    task automatic random_messages(input int n_plain);
        int                  done_plain;
        int                  pick;
        logic [LETTER_W-1:0] ltr;
        logic [LETTER_W-1:0] last_plain;
        done_plain = 0;
        last_plain = LETTER_X;
        while (done_plain < n_plain) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                queue_beat(CMD_FINISH, LETTER_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
            end else if (pick < 8) begin
                queue_beat(CMD_KEY, LETTER_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
            end else if (pick < 11) begin
                queue_beat(CMD_IGNORED, LETTER_W'($urandom_range(0, 31)),
                           1'($urandom_range(0, 1)));
            end else if (pick < 14) begin
                queue_beat(CMD_PLAIN, LETTER_W'($urandom_range(ALPHABET, 31)),
                           1'($urandom_range(0, 1)));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 20) begin
                    ltr = last_plain;
                end else if (pick < 26) begin
                    ltr = LETTER_J;
                end else begin
                    ltr = LETTER_W'($urandom_range(0, ALPHABET - 1));
                end
                last_plain = ltr;
                queue_beat(CMD_PLAIN, ltr, $urandom_range(0, 9) == 0);
                done_plain++;
            end
        end
    endtask

    // Sender stops until every beat is taken and every cipher letter has come back
    task automatic wait_drained;
        do begin
            @(negedge aclk);
        end while (beats_taken != beats_queued || cipher_due.size() != 0);
        @(posedge aclk);
    endtask

    // Input driver: next beat from the backlog, with random gaps
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || in_beat_taken)) begin
            if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                drv_beat = cmd_backlog.pop_front();
                s_valid          <= 1'b1;
                s_cmd            <= drv_beat.cmd;
                s_letter         <= drv_beat.letter;
                s_end_of_message <= drv_beat.eom;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Output receiver: random back-pressure, plus one long hold on request
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: predict on each input beat, check each cipher beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_beat_taken = 1'b0;
        end else begin
            in_beat_taken = s_valid && s_ready;
            out_taken     = m_valid && m_ready;
            if (in_beat_taken) begin
                playfair_step(s_cmd, s_letter, s_end_of_message);
                beats_taken++;
            end
            if (out_taken) begin
                if (cipher_due.size() == 0) begin
                    $display("%0t: unexpected beat: letter %0d pair_last %0b message_last %0b",
                             $time, m_cipher_letter, m_pair_last, m_message_last);
                    fails++;
                end else begin
                    want = cipher_due.pop_front();
                    if (m_cipher_letter !== want.letter) begin
                        $display("%0t: cipher_letter expected %0d got %0d",
                                 $time, want.letter, m_cipher_letter);
                        fails++;
                    end
                    if (m_pair_last !== want.pair_last) begin
                        $display("%0t: pair_last expected %0b got %0b",
                                 $time, want.pair_last, m_pair_last);
                        fails++;
                    end
                    if (m_message_last !== want.message_last) begin
                        $display("%0t: message_last expected %0b got %0b",
                                 $time, want.message_last, m_message_last);
                        fails++;
                    end
                end
            end
            stall_cycles = (in_beat_taken || out_taken) ? 0 : stall_cycles + 1;
        end
    end

    // Watchdog on cycles with no beat on either side
    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("FAIL playfair_cipher_encryptor_unit");
        $finish;
    end

    initial begin
        int key_len;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 24;
        recv_idle_pct = 62;

        // Key entry: junk, j folding onto i, repeats, alphabet ends, then a random key
        queue_beat(CMD_IGNORED, LETTER_W'(5), 1'b0);
        queue_beat(CMD_PLAIN, CODE_TOP, 1'b1);
        queue_beat(CMD_KEY, CODE_TOP, 1'b0);
        queue_beat(CMD_KEY, LETTER_J, 1'b0);
        queue_beat(CMD_KEY, LETTER_I, 1'b0);
        queue_beat(CMD_KEY, LETTER_LAST, 1'b1);
        queue_beat(CMD_KEY, '0, 1'b0);
        queue_beat(CMD_KEY, LETTER_LAST, 1'b0);
        key_len = ($urandom_range(0, 3) == 0) ? 90 : $urandom_range(0, 20);
        for (int i = 0; i < key_len; i++) begin
            queue_beat(CMD_KEY, LETTER_W'($urandom_range(0, ALPHABET - 1)), 1'b0);
        end
        queue_beat(CMD_FINISH, CODE_TOP, 1'b1);
        wait_drained();

        // Directed plaintext: row with wrap, column, rectangle, column with wrap
        queue_beat(CMD_PLAIN, sq_cell[3], 1'b0);
        queue_beat(CMD_PLAIN, sq_cell[4], 1'b0);
        queue_beat(CMD_PLAIN, sq_cell[2], 1'b0);
        queue_beat(CMD_PLAIN, sq_cell[7], 1'b0);
        queue_beat(CMD_PLAIN, sq_cell[0], 1'b0);
        queue_beat(CMD_PLAIN, sq_cell[6], 1'b0);
        queue_beat(CMD_PLAIN, sq_cell[4], 1'b0);
        queue_beat(CMD_PLAIN, sq_cell[24], 1'b0);
        // doubled letter, a pair of x, j followed by i
        queue_beat(CMD_PLAIN, '0, 1'b0);
        queue_beat(CMD_PLAIN, '0, 1'b0);
        queue_beat(CMD_PLAIN, LETTER_X, 1'b0);
        queue_beat(CMD_PLAIN, LETTER_X, 1'b0);
        queue_beat(CMD_PLAIN, LETTER_J, 1'b0);
        queue_beat(CMD_PLAIN, LETTER_I, 1'b0);
        // odd-length end padded with x, then a held letter dropped by finish
        queue_beat(CMD_PLAIN, LETTER_LAST, 1'b1);
        queue_beat(CMD_PLAIN, LETTER_W'(1), 1'b0);
        queue_beat(CMD_FINISH, '0, 1'b0);
        queue_beat(CMD_PLAIN, LETTER_W'(2), 1'b0);
        queue_beat(CMD_PLAIN, LETTER_W'(2), 1'b1);

        // Long receiver hold while the sender keeps offering
        hold_request = 1'b1;
        random_messages(230);
        wait_drained();

        send_idle_pct = 62;
        recv_idle_pct = 24;
        random_messages(230);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_messages(230);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (cipher_due.size() != 0) begin
            $display("%0t: %0d cipher letters never arrived", $time, cipher_due.size());
            fails++;
        end
        if (fails == 0) begin
            $display("PASS playfair_cipher_encryptor_unit");
        end else begin
            $display("FAIL playfair_cipher_encryptor_unit");
        end
        $finish;
    end

endmodule
